// ----- rtl/priority_task_table_top_macros.svh -----
// Assertion macros used by the priority task table checker.
`ifndef PRIORITY_TASK_TABLE_TOP_MACROS_SVH
`define PRIORITY_TASK_TABLE_TOP_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define PTT_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("priority task table check failed");

// Check that cons holds in the cycle after ante.
`define PTT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("priority task table check failed");

`endif

// ----- rtl/ptt_pkg.sv -----
// Types, constants and command/status structs of the priority task table.
package ptt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ID_W        = 32;
    localparam int PRI_W       = 16;
    localparam int REQ_W       = 2;
    localparam int STS_W       = 2;

    localparam int S_TDATA_W = ((ID_W + PRI_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((ID_W + STS_W + 7) / 8) * 8;

    localparam logic [REQ_W-1:0] REQ_ADD = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DEL = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RUN = 2'd2;

    localparam logic [STS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STS_W-1:0] ST_MISSING = 2'd2;
    localparam logic [STS_W-1:0] ST_EMPTY   = 2'd3;

    typedef enum logic [1:0] {
        RD_A,
        RD_B,
        RD_A1
    } rd_sel_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_APPEND,
        WR_SWAP_A,
        WR_SWAP_P,
        WR_SHIFT
    } wr_sel_t;

    typedef enum logic {
        EMIT_REQ,
        EMIT_ENTRY
    } emit_src_t;

    typedef struct packed {
        logic             load_req;
        logic             idx_clr;
        logic             idx_inc;
        logic             sort_load;
        logic             scan_step;
        logic             count_inc;
        logic             count_dec;
        logic             emit;
        emit_src_t        emit_src;
        logic [STS_W-1:0] emit_status;
        logic             emit_last;
        rd_sel_t          rd_sel;
        wr_sel_t          wr_sel;
    } ptt_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic             full;
        logic             empty;
        logic             a_last;
        logic             b_last;
        logic             id_match;
        logic             pick_moved;
        logic             out_free;
    } ptt_stat_t;

endpackage

// ----- rtl/ptt_dpath.sv -----
// Datapath of the priority task table: entry storage, index registers, output register.
module ptt_dpath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  ptt_pkg::ptt_cmd_t                   cmd,
    output ptt_pkg::ptt_stat_t                  stat,
    input  logic [ptt_pkg::REQ_W-1:0]           in_req_type,
    input  logic [ptt_pkg::ID_W-1:0]            in_task_id,
    input  logic [ptt_pkg::PRI_W-1:0]           in_task_priority,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ptt_pkg::ID_W-1:0]            out_id,
    output logic [ptt_pkg::STS_W-1:0]           out_status,
    output logic                                out_last
);

    logic [ptt_pkg::ID_W-1:0]  ids_reg  [ptt_pkg::TABLE_DEPTH];
    logic [ptt_pkg::PRI_W-1:0] pris_reg [ptt_pkg::TABLE_DEPTH];

    logic [ptt_pkg::CNT_W-1:0] count_reg, count_next;
    logic [ptt_pkg::REQ_W-1:0] req_type_reg;
    logic [ptt_pkg::ID_W-1:0]  req_id_reg;
    logic [ptt_pkg::PRI_W-1:0] req_pri_reg;

    logic [ptt_pkg::IDX_W-1:0] a_reg, b_reg, pick_reg;
    logic [ptt_pkg::PRI_W-1:0] best_reg, a_pri_reg;
    logic [ptt_pkg::ID_W-1:0]  a_id_reg, pick_id_reg;

    logic                      out_valid_reg, out_valid_next;
    logic [ptt_pkg::ID_W-1:0]  out_id_reg;
    logic [ptt_pkg::STS_W-1:0] out_status_reg;
    logic                      out_last_reg;

    logic [ptt_pkg::IDX_W-1:0] rd_idx, wr_idx;
    logic [ptt_pkg::ID_W-1:0]  rd_id, wr_id;
    logic [ptt_pkg::PRI_W-1:0] rd_pri, wr_pri;
    logic                      wr_en;
    logic                      out_free;

    always_comb begin
        case (cmd.rd_sel)
            ptt_pkg::RD_A:  rd_idx = a_reg;
            ptt_pkg::RD_B:  rd_idx = b_reg;
            ptt_pkg::RD_A1: rd_idx = a_reg + ptt_pkg::IDX_W'(1);
            default:        rd_idx = a_reg;
        endcase
    end

    assign rd_id  = ids_reg[rd_idx];
    assign rd_pri = pris_reg[rd_idx];

    always_comb begin
        wr_en  = 1'b1;
        wr_idx = a_reg;
        wr_id  = rd_id;
        wr_pri = rd_pri;
        case (cmd.wr_sel)
            ptt_pkg::WR_APPEND: begin
                wr_idx = count_reg[ptt_pkg::IDX_W-1:0];
                wr_id  = req_id_reg;
                wr_pri = req_pri_reg;
            end
            ptt_pkg::WR_SWAP_A: begin
                wr_idx = a_reg;
                wr_id  = pick_id_reg;
                wr_pri = best_reg;
            end
            ptt_pkg::WR_SWAP_P: begin
                wr_idx = pick_reg;
                wr_id  = a_id_reg;
                wr_pri = a_pri_reg;
            end
            ptt_pkg::WR_SHIFT: begin
                wr_idx = a_reg;
                wr_id  = rd_id;
                wr_pri = rd_pri;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ids_reg[wr_idx]  <= wr_id;
            pris_reg[wr_idx] <= wr_pri;
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.count_inc) begin
            count_next = count_reg + ptt_pkg::CNT_W'(1);
        end else if (cmd.count_dec) begin
            count_next = count_reg - ptt_pkg::CNT_W'(1);
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.emit) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_type_reg <= in_req_type;
            req_id_reg   <= in_task_id;
            req_pri_reg  <= in_task_priority;
        end
        if (cmd.idx_clr) begin
            a_reg <= '0;
        end else if (cmd.idx_inc) begin
            a_reg <= a_reg + ptt_pkg::IDX_W'(1);
        end
        if (cmd.sort_load) begin
            a_id_reg    <= rd_id;
            a_pri_reg   <= rd_pri;
            best_reg    <= rd_pri;
            pick_reg    <= a_reg;
            pick_id_reg <= rd_id;
            b_reg       <= a_reg + ptt_pkg::IDX_W'(1);
        end else if (cmd.scan_step) begin
            if (rd_pri < best_reg) begin
                best_reg    <= rd_pri;
                pick_reg    <= b_reg;
                pick_id_reg <= rd_id;
            end
            b_reg <= b_reg + ptt_pkg::IDX_W'(1);
        end
        if (cmd.emit) begin
            out_id_reg     <= (cmd.emit_src == ptt_pkg::EMIT_ENTRY) ? rd_id : req_id_reg;
            out_status_reg <= cmd.emit_status;
            out_last_reg   <= cmd.emit_last;
        end
    end

    always_comb begin
        stat.req_type   = req_type_reg;
        stat.full       = (count_reg == ptt_pkg::CNT_W'(ptt_pkg::TABLE_DEPTH));
        stat.empty      = (count_reg == '0);
        stat.a_last     = (({1'b0, a_reg} + ptt_pkg::CNT_W'(1)) == count_reg);
        stat.b_last     = (({1'b0, b_reg} + ptt_pkg::CNT_W'(1)) == count_reg);
        stat.id_match   = (rd_id == req_id_reg);
        stat.pick_moved = (pick_reg != a_reg);
        stat.out_free   = out_free;
    end

    assign out_valid  = out_valid_reg;
    assign out_id     = out_id_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;

endmodule

// ----- rtl/ptt_ctrl.sv -----
// Controller state machine of the priority task table.
module ptt_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  ptt_pkg::ptt_stat_t stat,
    output ptt_pkg::ptt_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_APPEND,
        S_SORT_CHK,
        S_SORT_A,
        S_SORT_SCAN,
        S_SORT_SWAP,
        S_SORT_SWAP2,
        S_FIND,
        S_SHIFT,
        S_RESULT,
        S_LIST
    } state_t;

    state_t                    state_reg, state_next;
    logic [ptt_pkg::STS_W-1:0] status_reg, status_next;

    always_comb begin
        state_next      = state_reg;
        status_next     = status_reg;
        in_ready        = 1'b0;
        cmd             = '0;
        cmd.emit_src    = ptt_pkg::EMIT_REQ;
        cmd.rd_sel      = ptt_pkg::RD_A;
        cmd.wr_sel      = ptt_pkg::WR_NONE;
        cmd.emit_status = ptt_pkg::ST_OK;
        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE: begin
                case (stat.req_type)
                    ptt_pkg::REQ_ADD: begin
                        if (stat.full) begin
                            status_next = ptt_pkg::ST_FULL;
                            state_next  = S_RESULT;
                        end else begin
                            state_next = S_APPEND;
                        end
                    end
                    ptt_pkg::REQ_DEL: begin
                        if (stat.empty) begin
                            status_next = ptt_pkg::ST_MISSING;
                            state_next  = S_RESULT;
                        end else begin
                            cmd.idx_clr = 1'b1;
                            state_next  = S_FIND;
                        end
                    end
                    ptt_pkg::REQ_RUN: begin
                        if (stat.empty) begin
                            status_next = ptt_pkg::ST_EMPTY;
                            state_next  = S_RESULT;
                        end else begin
                            cmd.idx_clr = 1'b1;
                            state_next  = S_LIST;
                        end
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_APPEND: begin
                cmd.wr_sel    = ptt_pkg::WR_APPEND;
                cmd.count_inc = 1'b1;
                cmd.idx_clr   = 1'b1;
                state_next    = S_SORT_CHK;
            end
            S_SORT_CHK: begin
                if (stat.a_last) begin
                    status_next = ptt_pkg::ST_OK;
                    state_next  = S_RESULT;
                end else begin
                    state_next = S_SORT_A;
                end
            end
            S_SORT_A: begin
                cmd.rd_sel    = ptt_pkg::RD_A;
                cmd.sort_load = 1'b1;
                state_next    = S_SORT_SCAN;
            end
            S_SORT_SCAN: begin
                cmd.rd_sel    = ptt_pkg::RD_B;
                cmd.scan_step = 1'b1;
                if (stat.b_last) begin
                    state_next = S_SORT_SWAP;
                end
            end
            S_SORT_SWAP: begin
                if (stat.pick_moved) begin
                    cmd.wr_sel = ptt_pkg::WR_SWAP_A;
                    state_next = S_SORT_SWAP2;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SORT_CHK;
                end
            end
            S_SORT_SWAP2: begin
                cmd.wr_sel  = ptt_pkg::WR_SWAP_P;
                cmd.idx_inc = 1'b1;
                state_next  = S_SORT_CHK;
            end
            S_FIND: begin
                cmd.rd_sel = ptt_pkg::RD_A;
                if (stat.id_match) begin
                    state_next = S_SHIFT;
                end else if (stat.a_last) begin
                    status_next = ptt_pkg::ST_MISSING;
                    state_next  = S_RESULT;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_SHIFT: begin
                if (stat.a_last) begin
                    cmd.count_dec = 1'b1;
                    status_next   = ptt_pkg::ST_OK;
                    state_next    = S_RESULT;
                end else begin
                    cmd.rd_sel  = ptt_pkg::RD_A1;
                    cmd.wr_sel  = ptt_pkg::WR_SHIFT;
                    cmd.idx_inc = 1'b1;
                end
            end
            S_RESULT: begin
                if (stat.out_free) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_src    = ptt_pkg::EMIT_REQ;
                    cmd.emit_status = status_reg;
                    cmd.emit_last   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_LIST: begin
                cmd.rd_sel = ptt_pkg::RD_A;
                if (stat.out_free) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_src    = ptt_pkg::EMIT_ENTRY;
                    cmd.emit_status = ptt_pkg::ST_OK;
                    cmd.emit_last   = stat.a_last;
                    cmd.idx_inc     = 1'b1;
                    if (stat.a_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            status_reg <= ptt_pkg::ST_OK;
        end else begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

endmodule

// ----- rtl/priority_task_table_top.sv -----
// Top level of the priority task table: stream ports, controller and datapath.
// Holds up to TABLE_DEPTH tasks in ascending priority order and takes one request
// at a time. A request is taken only when the controller is idle; results leave
// through an output register, so the next request can enter while the last result
// waits. The table has a single read and a single write port, so entries are read
// and written one at a time: an add appends the task and then runs a selection sort
// pass over the table (this pass dominates), a swap writing both entries in turn;
// a delete searches for the ID and shifts the later entries down; a run lists every
// entry in order and can stall on the result side.
// No clearing pass follows reset: the table is usable at once.
module priority_task_table_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ptt_pkg::S_TDATA_W-1:0]   s_tdata,   // task_id, task_priority
    input  logic [ptt_pkg::REQ_W-1:0]       s_tuser,   // req_type
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ptt_pkg::M_TDATA_W-1:0]   m_tdata,   // out_id, status, zero fill
    output logic                            m_tlast    // last
);

    ptt_pkg::ptt_cmd_t         cmd;
    ptt_pkg::ptt_stat_t        stat;
    logic [ptt_pkg::ID_W-1:0]  out_id;
    logic [ptt_pkg::STS_W-1:0] out_status;

    ptt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ptt_dpath u_dpath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .in_req_type      (s_tuser),
        .in_task_id       (s_tdata[ptt_pkg::ID_W-1:0]),
        .in_task_priority (s_tdata[ptt_pkg::ID_W+ptt_pkg::PRI_W-1:ptt_pkg::ID_W]),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .out_id           (out_id),
        .out_status       (out_status),
        .out_last         (m_tlast)
    );

    assign m_tdata = ptt_pkg::M_TDATA_W'({out_status, out_id});

endmodule

// ----- rtl/ptt_checker.sv -----
// Port-level checker of the priority task table and its bind to the top level.
`include "priority_task_table_top_macros.svh"

module ptt_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ptt_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tlast
);

    logic [ptt_pkg::STS_W-1:0] m_status;

    assign m_status = m_tdata[ptt_pkg::ID_W+ptt_pkg::STS_W-1:ptt_pkg::ID_W];

    `PTT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    `PTT_ASSERT_SAME(a_fail_is_last, aclk, aresetn, m_tvalid && (m_status != ptt_pkg::ST_OK), m_tlast)
    `PTT_ASSERT_SAME(a_no_take_mid_list, aclk, aresetn, m_tvalid && !m_tlast, !s_tready)
    `PTT_ASSERT_SAME(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[ptt_pkg::M_TDATA_W-1:ptt_pkg::ID_W+ptt_pkg::STS_W] == '0)

endmodule

bind priority_task_table_top ptt_checker u_chk (.*);

// ----- bench/priority_task_table_top_test.sv -----
// Self-checking bench for the priority task table: directed and random requests against a predictor.
`timescale 1ns / 100ps

module priority_task_table_top_test;

    localparam logic [ptt_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [ptt_pkg::ID_W-1:0]  id;
        logic [ptt_pkg::STS_W-1:0] status;
        logic                      last;
    } task_result_t;

    class task_table_tracker;
        logic [ptt_pkg::ID_W-1:0]  entry_id[ptt_pkg::TABLE_DEPTH];
        logic [ptt_pkg::PRI_W-1:0] entry_pri[ptt_pkg::TABLE_DEPTH];
        int                        entry_count = 0;
        task_result_t              pending_results[$];
        int                        mismatch_count = 0;

        function void push_result(logic [ptt_pkg::ID_W-1:0] id,
                                  logic [ptt_pkg::STS_W-1:0] status, logic last);
            task_result_t r;
            r.id = id;
            r.status = status;
            r.last = last;
            pending_results = {pending_results, r};
        endfunction

        function void accept_request(logic [ptt_pkg::REQ_W-1:0] req,
                                     logic [ptt_pkg::ID_W-1:0] id,
                                     logic [ptt_pkg::PRI_W-1:0] pri);
            int a;
            int b;
            int pick;
            int hit;
            logic [ptt_pkg::PRI_W-1:0] best;
            logic [ptt_pkg::ID_W-1:0]  tid;
            logic [ptt_pkg::PRI_W-1:0] tpr;
            case (req)
                ptt_pkg::REQ_ADD: begin
                    if (entry_count >= ptt_pkg::TABLE_DEPTH) begin
                        push_result(id, ptt_pkg::ST_FULL, 1'b1);
                    end else begin
                        entry_id[entry_count] = id;
                        entry_pri[entry_count] = pri;
                        entry_count++;
                        for (a = 0; a + 1 < entry_count; a++) begin
                            best = entry_pri[a];
                            pick = a;
                            for (b = a + 1; b < entry_count; b++) begin
                                if (entry_pri[b] < best) begin
                                    best = entry_pri[b];
                                    pick = b;
                                end
                            end
                            if (best != entry_pri[a]) begin
                                tid = entry_id[a];
                                tpr = entry_pri[a];
                                entry_id[a] = entry_id[pick];
                                entry_pri[a] = entry_pri[pick];
                                entry_id[pick] = tid;
                                entry_pri[pick] = tpr;
                            end
                        end
                        push_result(id, ptt_pkg::ST_OK, 1'b1);
                    end
                end
                ptt_pkg::REQ_DEL: begin
                    hit = -1;
                    for (a = 0; a < entry_count; a++) begin
                        if (hit < 0 && entry_id[a] == id) hit = a;
                    end
                    if (hit < 0) begin
                        push_result(id, ptt_pkg::ST_MISSING, 1'b1);
                    end else begin
                        for (a = hit; a + 1 < entry_count; a++) begin
                            entry_id[a] = entry_id[a + 1];
                            entry_pri[a] = entry_pri[a + 1];
                        end
                        entry_count--;
                        push_result(id, ptt_pkg::ST_OK, 1'b1);
                    end
                end
                ptt_pkg::REQ_RUN: begin
                    if (entry_count == 0) begin
                        push_result(id, ptt_pkg::ST_EMPTY, 1'b1);
                    end else begin
                        for (a = 0; a < entry_count; a++) begin
                            push_result(entry_id[a], ptt_pkg::ST_OK, a + 1 == entry_count);
                        end
                    end
                end
                default: begin
                end
            endcase
        endfunction

        function void check_result(logic [ptt_pkg::ID_W-1:0] id,
                                   logic [ptt_pkg::STS_W-1:0] status, logic last);
            task_result_t exp_r;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: id %h status %0d last %0b", id, status, last);
                return;
            end
            exp_r = pending_results.pop_front();
            if (exp_r.id !== id || exp_r.status !== status || exp_r.last !== last) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display({"result mismatch: expected id %h status %0d last %0b, ",
                              "got id %h status %0d last %0b"},
                             exp_r.id, exp_r.status, exp_r.last, id, status, last);
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic                          aclk = 1'b0;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [ptt_pkg::S_TDATA_W-1:0] s_tdata;
    logic [ptt_pkg::REQ_W-1:0]     s_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [ptt_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          m_tlast;

    int tx_idle_pct;
    int rx_idle_pct;
    task_table_tracker tracker;

    priority_task_table_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_tready = ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_result(m_tdata[ptt_pkg::ID_W-1:0],
                                 m_tdata[ptt_pkg::ID_W+ptt_pkg::STS_W-1:ptt_pkg::ID_W],
                                 m_tlast);
    end

    task automatic send_request(input logic [ptt_pkg::REQ_W-1:0] req,
                                input logic [ptt_pkg::ID_W-1:0] id,
                                input logic [ptt_pkg::PRI_W-1:0] pri);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tdata = '0;
        s_tdata[ptt_pkg::ID_W-1:0] = id;
        s_tdata[ptt_pkg::ID_W+ptt_pkg::PRI_W-1:ptt_pkg::ID_W] = pri;
        s_tuser = req;
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tracker.accept_request(req, id, pri);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid = 1'b0;
        while (tracker.pending() != 0) @(negedge aclk);
    endtask

    task automatic send_random_request(input bit fill_bias, output bit counted);
        int r;
        int add_w;
        int del_w;
        logic [ptt_pkg::REQ_W-1:0] req;
        logic [ptt_pkg::ID_W-1:0]  id;
        logic [ptt_pkg::PRI_W-1:0] pri;
        r = $urandom_range(99);
        add_w = fill_bias ? 60 : 25;
        del_w = add_w + (fill_bias ? 20 : 50);
        if (r < add_w) req = ptt_pkg::REQ_ADD;
        else if (r < del_w) req = ptt_pkg::REQ_DEL;
        else if (r < 97) req = ptt_pkg::REQ_RUN;
        else req = REQ_UNUSED;
        id = $urandom;
        if (tracker.entry_count > 0) begin
            if ((req == ptt_pkg::REQ_DEL && $urandom_range(9) < 7) ||
                (req == ptt_pkg::REQ_ADD && $urandom_range(3) == 0))
                id = tracker.entry_id[$urandom_range(tracker.entry_count - 1)];
        end
        pri = ($urandom_range(3) == 0) ? ptt_pkg::PRI_W'($urandom_range(3))
                                       : ptt_pkg::PRI_W'($urandom);
        send_request(req, id, pri);
        counted = (req != REQ_UNUSED);
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct, input int items);
        int n;
        bit counted;
        bit fill_bias;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        n = 0;
        fill_bias = 1'b0;
        while (n < items) begin
            if (n % 20 == 0) fill_bias = ~fill_bias;
            if (n == items / 2) drain_results();
            send_random_request(fill_bias, counted);
            if (counted) n++;
        end
        drain_results();
    endtask

    initial begin
        int i;
        logic [ptt_pkg::ID_W-1:0]  id;
        logic [ptt_pkg::PRI_W-1:0] pri;
        tracker = new;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = ptt_pkg::REQ_ADD;
        m_tready = 1'b0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;

        send_request(ptt_pkg::REQ_RUN, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(ptt_pkg::REQ_DEL, 32'h0000_0000, 16'h0000);
        send_request(REQ_UNUSED, 32'h1357_9BDF, 16'hA5A5);
        for (i = 0; i < ptt_pkg::TABLE_DEPTH; i++) begin
            id = (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF
                                             : 32'hC0DE_0000 + ptt_pkg::ID_W'(i % 5);
            pri = (i == 0 || i == 15) ? 16'hFFFF : (i == 1) ? 16'h0000
                                                            : ptt_pkg::PRI_W'((15 - i) % 4);
            send_request(ptt_pkg::REQ_ADD, id, pri);
        end
        send_request(ptt_pkg::REQ_ADD, 32'h8000_0001, 16'h0001);
        send_request(ptt_pkg::REQ_RUN, 32'h0, 16'h0);
        send_request(ptt_pkg::REQ_DEL, 32'hC0DE_0002, 16'hFFFF);
        send_request(ptt_pkg::REQ_DEL, 32'h7777_7777, 16'h0);
        send_request(ptt_pkg::REQ_RUN, 32'h0, 16'h0);
        drain_results();

        run_phase(11, 59, 64);
        run_phase(59, 11, 64);
        run_phase(0, 0, 63);

        repeat (200) @(negedge aclk);
        if (tracker.mismatch_count == 0 && tracker.pending() == 0) begin
            $display("priority_task_table_top_test: PASS");
        end else begin
            $display("priority_task_table_top_test: FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("priority_task_table_top_test: FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/ptt_pkg.sv
rtl/ptt_dpath.sv
rtl/ptt_ctrl.sv
rtl/priority_task_table_top.sv
rtl/ptt_checker.sv
bench/priority_task_table_top_test.sv
